[sv/lpps_pkg.sv]
// lpps_pkg: shared constants, widths, codes and types of the line position pid steering block
// used by lpps_div, line_position_pid_steering and lpps_check; depends on nothing

package lpps_pkg;

  // sensor array and scaling
  localparam int SENSOR_COUNT = 8;
  localparam int FULL_SCALE   = 1000;
  localparam int SAMPLE_BITS  = 10;

  // fixed field widths
  localparam int LEVEL_W   = 10;
  localparam int GAIN_W    = 16;
  localparam int BASE_W    = 15;
  localparam int SPEED_W   = 16;
  localparam int POS_W     = 13;
  localparam int DATA_W    = 16;
  localparam int REG_W     = 3;
  localparam int FRAC_BITS = 12;

  // geometry of the track
  localparam int RIGHT_EDGE = FULL_SCALE * (SENSOR_COUNT - 1);
  localparam int CENTRE     = RIGHT_EDGE / 2;

  // raw sample mask
  localparam logic [LEVEL_W-1:0] SMASK = LEVEL_W'((1 << SAMPLE_BITS) - 1);

  // derived widths
  localparam int IDX_W    = $clog2(SENSOR_COUNT);
  localparam int SCALE_W  = $clog2(FULL_SCALE + 1);
  localparam int QPOS_W   = $clog2(RIGHT_EDGE + 1);
  localparam int POSQ_W   = (QPOS_W > POS_W) ? QPOS_W : POS_W;
  localparam int LCMP_W   = (SCALE_W > LEVEL_W) ? SCALE_W : LEVEL_W;
  localparam int TOTAL_W  = $clog2(SENSOR_COUNT * FULL_SCALE + 1);
  localparam int SNUM_MAX = ((1 << LEVEL_W) - 1) * FULL_SCALE;
  localparam int WSUM_MAX = FULL_SCALE * RIGHT_EDGE * SENSOR_COUNT / 2;
  localparam int WSUM_W   = $clog2(WSUM_MAX + 1);
  localparam int NUM_W    = $clog2(((SNUM_MAX > WSUM_MAX) ? SNUM_MAX : WSUM_MAX) + 1);
  localparam int DIV_W    = (TOTAL_W > LEVEL_W) ? TOTAL_W : LEVEL_W;
  localparam int QMAX_W   = (QPOS_W > SCALE_W) ? QPOS_W : SCALE_W;
  localparam int CNT_W    = $clog2(QMAX_W + 1);

  // shared multiplier and pid accumulator
  localparam int MUL_B_W = POSQ_W + 1;
  localparam int PROD_W  = GAIN_W + 1 + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int CTRL_W  = ACC_W - FRAC_BITS;
  localparam int SUM_W   = CTRL_W + 1;

  // configuration register indexes
  typedef enum logic [REG_W-1:0] {
    REG_BLACK  = 3'd0,
    REG_WHITE  = 3'd1,
    REG_PROP   = 3'd2,
    REG_SUM    = 3'd3,
    REG_DIFF   = 3'd4,
    REG_BASE   = 3'd5,
    REG_ONLINE = 3'd6,
    REG_WEIGHT = 3'd7
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_SDIV,
    S_ACC,
    S_WADD,
    S_POS,
    S_PDIV,
    S_ERR,
    S_MP,
    S_MS,
    S_MD,
    S_MA,
    S_CTRL,
    S_OUT
  } state_t;

  // divider command
  typedef struct packed {
    logic start;
    logic wide;
  } div_ctl_t;

endpackage

[sv/lpps_div.sv]
// lpps_div: bit-serial restoring divider, one quotient bit per cycle
// depends on lpps_pkg; narrow runs give a scaled sample, wide runs give the line position

module lpps_div (
  input  logic                       clk,
  input  logic                       rst,
  input  lpps_pkg::div_ctl_t         ctl,
  input  logic [lpps_pkg::NUM_W-1:0] numer,
  input  logic [lpps_pkg::DIV_W-1:0] denom,
  output logic                       done,
  output logic [lpps_pkg::QMAX_W-1:0] quot
);
  import lpps_pkg::*;

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [NUM_W-1:0] sr;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_diff;
  logic             ge;

  // one trial subtraction per cycle
  assign rem_sh   = {rem, sr[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign ge       = (rem_sh >= {1'b0, dvs});

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        cnt <= ctl.wide ? CNT_W'(QPOS_W) : CNT_W'(SCALE_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // remainder, numerator shifter and quotient; the top part of the numerator
  // is already below the divisor since the quotient fits the run length
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvs  <= denom;
      quot <= '0;
      if (ctl.wide) begin
        rem <= DIV_W'(numer >> QPOS_W);
        sr  <= numer << (NUM_W - QPOS_W);
      end else begin
        rem <= DIV_W'(numer >> SCALE_W);
        sr  <= numer << (NUM_W - SCALE_W);
      end
    end else if (cnt != '0) begin
      rem  <= ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      sr   <= sr << 1;
      quot <= {quot[QMAX_W-2:0], ge};
    end
  end

endmodule

[sv/line_position_pid_steering.sv]
// line_position_pid_steering: top level, sensor scaling, line position and pid wheel speeds
// depends on lpps_pkg and lpps_div

// One transaction carries eight raw ground-sensor samples and returns one result: both wheel
// speeds, the line position, the tracking error and the line-seen flag. Items are processed
// one at a time by a small sequencer around a shared bit-serial divider and one 17x14
// multiplier; sample_stall stays high while an item is in work. A sample inside the
// black..white band needs a division that produces 10 quotient bits, a sample out of
// band is clamped without one; the tail needs the 13-bit position division only when the
// weighted average is taken. A new transaction is not taken until the previous item has
// reached its result. The finished result sits in an output register, so the next item is
// taken while the previous result still waits on result_stall. Configuration writes take
// effect at once and are meant for when the block is idle.

module line_position_pid_steering (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               write_enable,
  input  logic [lpps_pkg::REG_W-1:0]         write_index,
  input  logic [lpps_pkg::DATA_W-1:0]        write_data,
  // sample channel
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic [lpps_pkg::LEVEL_W-1:0]       sample_0,
  input  logic [lpps_pkg::LEVEL_W-1:0]       sample_1,
  input  logic [lpps_pkg::LEVEL_W-1:0]       sample_2,
  input  logic [lpps_pkg::LEVEL_W-1:0]       sample_3,
  input  logic [lpps_pkg::LEVEL_W-1:0]       sample_4,
  input  logic [lpps_pkg::LEVEL_W-1:0]       sample_5,
  input  logic [lpps_pkg::LEVEL_W-1:0]       sample_6,
  input  logic [lpps_pkg::LEVEL_W-1:0]       sample_7,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [lpps_pkg::SPEED_W-1:0] left_speed,
  output logic signed [lpps_pkg::SPEED_W-1:0] right_speed,
  output logic [lpps_pkg::POS_W-1:0]         line_position,
  output logic signed [lpps_pkg::POS_W-1:0]  track_error,
  output logic                               line_seen
);
  import lpps_pkg::*;

  localparam logic signed [SUM_W-1:0] SPD_MAX = SUM_W'((2 ** (SPEED_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SPD_MIN = SUM_W'(-(2 ** (SPEED_W - 1)));

  // configuration registers
  logic [LEVEL_W-1:0] black_level;
  logic [LEVEL_W-1:0] white_level;
  logic [GAIN_W-1:0]  gain_prop;
  logic [GAIN_W-1:0]  gain_sum;
  logic [GAIN_W-1:0]  gain_diff;
  logic [BASE_W-1:0]  base_speed;
  logic [LEVEL_W-1:0] online_level;
  logic [LEVEL_W-1:0] weight_level;

  // sequencer and item state
  state_t             state;
  state_t             state_next;
  logic [LEVEL_W-1:0] samp [SENSOR_COUNT];
  logic [IDX_W-1:0]   idx;
  logic [SCALE_W-1:0] level;
  logic               contrib;
  logic               seen;
  logic               snap_left;
  logic [WSUM_W-1:0]  weighted;
  logic [TOTAL_W-1:0] total;
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   held_position;
  logic signed [POS_W-1:0] err;
  logic signed [POS_W-1:0] previous_error;

  // arithmetic
  logic [GAIN_W-1:0]          mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [ACC_W-1:0]    acc_adj;
  logic signed [CTRL_W-1:0]   ctrl;
  logic signed [SUM_W-1:0]    base_ext;
  logic signed [SUM_W-1:0]    ctrl_ext;
  logic signed [SUM_W-1:0]    spd_l;
  logic signed [SUM_W-1:0]    spd_r;
  logic signed [SPEED_W-1:0]  base16;
  logic signed [MUL_B_W-1:0]  e_sum;
  logic signed [MUL_B_W-1:0]  e_dif;
  logic [POSQ_W-1:0]          wconst;

  // divider hookup
  div_ctl_t           div_ctl;
  logic [NUM_W-1:0]   numer;
  logic [DIV_W-1:0]   denom;
  logic               div_done;
  logic [QMAX_W-1:0]  quot;

  // misc
  logic [LEVEL_W-1:0] raw;
  logic               degenerate;
  logic               in_band;
  logic               accept;
  logic               out_free;

  lpps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .ctl   (div_ctl),
    .numer (numer),
    .denom (denom),
    .done  (div_done),
    .quot  (quot)
  );

  function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    begin
      if (v > SPD_MAX) begin
        c = SPD_MAX;
      end else if (v < SPD_MIN) begin
        c = SPD_MIN;
      end else begin
        c = v;
      end
      return c[SPEED_W-1:0];
    end
  endfunction

  // handshake
  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;

  // current sample and its band test
  assign raw        = samp[idx];
  assign degenerate = (white_level <= black_level);
  assign in_band    = !degenerate && (raw > black_level) && (raw < white_level);
  assign wconst     = POSQ_W'(idx) * POSQ_W'(FULL_SCALE);

  // pid operands
  assign e_sum = MUL_B_W'(err) + MUL_B_W'(previous_error);
  assign e_dif = MUL_B_W'(err) - MUL_B_W'(previous_error);

  // truncation toward zero of the q21.12 sum
  assign acc_rnd = acc[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : '0;
  assign acc_adj = acc + acc_rnd;

  // wheel speed sums
  assign base_ext = {{(SUM_W - BASE_W){1'b0}}, base_speed};
  assign ctrl_ext = {{(SUM_W - CTRL_W){ctrl[CTRL_W-1]}}, ctrl};
  assign spd_l    = base_ext + ctrl_ext;
  assign spd_r    = base_ext - ctrl_ext;
  assign base16   = {{(SPEED_W - BASE_W){1'b0}}, base_speed};

  // next state, divider command and multiplier operands
  always_comb begin
    state_next = state;
    div_ctl    = '0;
    mul_a      = '0;
    mul_b      = '0;
    if (state == S_POS) begin
      numer = NUM_W'(weighted);
      denom = DIV_W'(total);
    end else begin
      numer = NUM_W'(LEVEL_W'(raw - black_level)) * NUM_W'(FULL_SCALE);
      denom = DIV_W'(LEVEL_W'(white_level - black_level));
    end
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        if (in_band) begin
          div_ctl.start = 1'b1;
          state_next    = S_SDIV;
        end else begin
          state_next = S_ACC;
        end
      end
      S_SDIV: begin
        if (div_done) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        mul_a      = GAIN_W'(level);
        mul_b      = {1'b0, wconst};
        state_next = S_WADD;
      end
      S_WADD: begin
        state_next = (idx == IDX_W'(SENSOR_COUNT - 1)) ? S_POS : S_SCALE;
      end
      S_POS: begin
        if (seen && (total != '0)) begin
          div_ctl.start = 1'b1;
          div_ctl.wide  = 1'b1;
          state_next    = S_PDIV;
        end else begin
          state_next = S_ERR;
        end
      end
      S_PDIV: begin
        if (div_done) begin
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        state_next = S_MP;
      end
      S_MP: begin
        mul_a      = gain_prop;
        mul_b      = MUL_B_W'(err);
        state_next = S_MS;
      end
      S_MS: begin
        mul_a      = gain_sum;
        mul_b      = e_sum;
        state_next = S_MD;
      end
      S_MD: begin
        mul_a      = gain_diff;
        mul_b      = e_dif;
        state_next = S_MA;
      end
      S_MA: begin
        state_next = S_CTRL;
      end
      S_CTRL: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration, held state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      black_level    <= LEVEL_W'(110);
      white_level    <= LEVEL_W'(520);
      gain_prop      <= GAIN_W'(3277);
      gain_sum       <= '0;
      gain_diff      <= GAIN_W'(82);
      base_speed     <= BASE_W'(3500);
      online_level   <= LEVEL_W'(200);
      weight_level   <= LEVEL_W'(50);
      held_position  <= '0;
      previous_error <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (write_enable) begin
        case (reg_idx_t'(write_index))
          REG_BLACK:  black_level  <= write_data[LEVEL_W-1:0];
          REG_WHITE:  white_level  <= write_data[LEVEL_W-1:0];
          REG_PROP:   gain_prop    <= write_data[GAIN_W-1:0];
          REG_SUM:    gain_sum     <= write_data[GAIN_W-1:0];
          REG_DIFF:   gain_diff    <= write_data[GAIN_W-1:0];
          REG_BASE:   base_speed   <= write_data[BASE_W-1:0];
          REG_ONLINE: online_level <= write_data[LEVEL_W-1:0];
          REG_WEIGHT: weight_level <= write_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (state == S_ERR) begin
        held_position <= position;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if ((state == S_OUT) && out_free) begin
        previous_error <= err;
        result_valid   <= 1'b1;
      end
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, mul_a}) * mul_b;
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          samp[0]  <= sample_0 & SMASK;
          samp[1]  <= sample_1 & SMASK;
          samp[2]  <= sample_2 & SMASK;
          samp[3]  <= sample_3 & SMASK;
          samp[4]  <= sample_4 & SMASK;
          samp[5]  <= sample_5 & SMASK;
          samp[6]  <= sample_6 & SMASK;
          samp[7]  <= sample_7 & SMASK;
          idx      <= '0;
          weighted <= '0;
          total    <= '0;
          seen     <= 1'b0;
        end
      end
      S_SCALE: begin
        // out of band or degenerate levels clamp without a division
        if (!in_band) begin
          level <= (degenerate || (raw <= black_level)) ? '0 : SCALE_W'(FULL_SCALE);
        end
      end
      S_SDIV: begin
        if (div_done) begin
          level <= SCALE_W'(quot);
        end
      end
      S_ACC: begin
        contrib <= (LCMP_W'(level) > LCMP_W'(weight_level));
        if (LCMP_W'(level) > LCMP_W'(online_level)) begin
          seen <= 1'b1;
        end
      end
      S_WADD: begin
        if (contrib) begin
          weighted <= weighted + prod[WSUM_W-1:0];
          total    <= total + TOTAL_W'(level);
        end
        idx <= idx + 1'b1;
      end
      S_POS: begin
        snap_left <= 1'b0;
        if (seen) begin
          // empty average keeps the held position
          position <= held_position;
        end else if (POSQ_W'(held_position) < POSQ_W'(CENTRE)) begin
          position  <= '0;
          snap_left <= 1'b1;
        end else begin
          position <= POS_W'(RIGHT_EDGE);
        end
      end
      S_PDIV: begin
        if (div_done) begin
          position <= POS_W'(quot);
        end
      end
      S_ERR: begin
        err <= position - POS_W'(CENTRE);
      end
      S_MS: begin
        acc <= ACC_W'(prod);
      end
      S_MD: begin
        acc <= acc + ACC_W'(prod);
      end
      S_MA: begin
        acc <= acc + ACC_W'(prod);
      end
      S_CTRL: begin
        ctrl <= acc_adj[ACC_W-1:FRAC_BITS];
      end
      S_OUT: begin
        if (out_free) begin
          line_position <= position;
          track_error   <= err;
          line_seen     <= seen;
          if (seen) begin
            left_speed  <= sat16(spd_l);
            right_speed <= sat16(spd_r);
          end else if (snap_left) begin
            left_speed  <= -base16;
            right_speed <= base16;
          end else begin
            left_speed  <= base16;
            right_speed <= -base16;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[sv/lpps_check.sv]
// lpps_check: port-level assertions for line_position_pid_steering, bound to the top level
// depends on lpps_pkg

module lpps_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_valid,
  input logic                                sample_stall,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic signed [lpps_pkg::SPEED_W-1:0] left_speed,
  input logic signed [lpps_pkg::SPEED_W-1:0] right_speed,
  input logic [lpps_pkg::POS_W-1:0]          line_position,
  input logic signed [lpps_pkg::POS_W-1:0]   track_error
,
  input logic                                line_seen
);
  import lpps_pkg::*;

  // a stalled result transaction stays offered
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // an accepted sample transaction keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("block ready right after a sample transaction");

  // reset leaves the block empty and ready
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("block not idle after reset");

  // error always tracks position against the centre
  a_error_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($unsigned(track_error) == POS_W'(line_position - POS_W'(CENTRE))))
    else $error("track error inconsistent with line position");

  // a lost line gives an edge position and a pure spin
  a_lost_spin: assert property (@(posedge clk) disable iff (rst)
    result_valid && !line_seen |->
      (left_speed == -right_speed) &&
      ((line_position == '0) || (line_position == POS_W'(RIGHT_EDGE))))
    else $error("lost line result is not an edge spin");

endmodule

bind line_position_pid_steering lpps_check u_lpps_check (.*);
